### src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

   localparam int DATA_W           = 32;
   localparam int OCC_W            = 6;
   localparam int DEFAULT_CAPACITY = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // What every cell of a row does when the row is updated.
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_FROM_LOW  = 2'd1,
      CELL_FROM_HIGH = 2'd2,
      CELL_APPEND    = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [DATA_W-1:0]  value;
   } deq_cell_cmd_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [DATA_W-1:0]  value;
   } deq_req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  popped_value;
      logic [OCC_W-1:0]          occupancy;
   } deq_rsp_type;

endpackage

### src/deq_cell.sv
// One storage cell of a queue row: holds a word, shifts to or from its neighbors.
module deq_cell
   import deq_pkg::*;
#(
   parameter int CNT_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                      clock,
   input  deq_cell_cmd_type          cmd,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [DATA_W-1:0]  low_data,
   input  logic signed [DATA_W-1:0]  high_data,
   output logic signed [DATA_W-1:0]  data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_FROM_LOW: begin
            data_in = low_data;
         end
         CELL_FROM_HIGH: begin
            data_in = high_data;
         end
         CELL_APPEND: begin
            // Only the first free cell takes the new word.
            if (count == CNT_W'(CELL_IDX)) begin
               data_in = cmd.value;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### src/deq_row.sv
// A row of cells holding queue contents packed from cell zero upward.
module deq_row
   import deq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                      clock,
   input  deq_cell_cmd_type          cmd,
   input  logic [CNT_W-1:0]          count,
   output logic signed [DATA_W-1:0]  head_data
);

   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic signed [DATA_W-1:0] low_data  [CAPACITY];
   logic signed [DATA_W-1:0] high_data [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // The new word enters at cell zero when the row shifts upward.
      if (i == 0) begin : g_first
         assign low_data[i] = cmd.value;
      end else begin : g_inner_low
         assign low_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign high_data[i] = cell_data[i];
      end else begin : g_inner_high
         assign high_data[i] = cell_data[i+1];
      end

      deq_cell #(
         .CNT_W    (CNT_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count),
         .low_data  (low_data[i]),
         .high_data (high_data[i]),
         .data      (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

### src/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// Usage: each word on the req_ channel is one operation (push back, push
// front, pop front, pop back) plus a value that pushes store. Each accepted
// operation gives exactly one word on the rsp_ channel with a status (ok,
// overflow, underflow), the popped value (zero unless a pop succeeded) and
// the occupancy afterward. A refused push or pop changes nothing.
// The response is registered, valid in the cycle after acceptance;
// throughput is one operation per cycle unless the receiver stalls. Two
// rows of cells hold the contents, one with the front at cell zero and
// one with the back at cell zero, so either end is read from a fixed cell
// and every update is a shift or an append. When the receiver stalls, the
// registered response holds and req_ready stays high only if that
// response is being taken in the same cycle. Synchronous reset empties the
// queue and drops any pending response, with no clearing pass.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  deq_req_type  req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output deq_rsp_type  rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   deq_rsp_type               rsp_payload_ff;
   deq_rsp_type               rsp_payload_in;
   deq_cell_cmd_type          front_cmd;
   deq_cell_cmd_type          back_cmd;
   logic signed [DATA_W-1:0]  front_head;
   logic signed [DATA_W-1:0]  back_head;
   logic                      accept;
   logic                      full;
   logic                      empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      front_cmd.op    = CELL_HOLD;
      front_cmd.value = req_payload.value;
      back_cmd.op     = CELL_HOLD;
      back_cmd.value  = req_payload.value;
      count_in        = count_ff;
      rsp_payload_in.status       = STATUS_OK;
      rsp_payload_in.popped_value = '0;

      if (accept) begin
         unique case (req_payload.kind)
            KIND_PUSH_BACK: begin
               if (full) begin
                  rsp_payload_in.status = STATUS_OVERFLOW;
               end else begin
                  front_cmd.op = CELL_APPEND;
                  back_cmd.op  = CELL_FROM_LOW;
                  count_in     = count_ff + 1'b1;
               end
            end
            KIND_PUSH_FRONT: begin
               if (full) begin
                  rsp_payload_in.status = STATUS_OVERFLOW;
               end else begin
                  front_cmd.op = CELL_FROM_LOW;
                  back_cmd.op  = CELL_APPEND;
                  count_in     = count_ff + 1'b1;
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  rsp_payload_in.status = STATUS_UNDERFLOW;
               end else begin
                  // The back row only loses its last valid cell, so a
                  // smaller count is all it needs.
                  rsp_payload_in.popped_value = front_head;
                  front_cmd.op = CELL_FROM_HIGH;
                  count_in     = count_ff - 1'b1;
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  rsp_payload_in.status = STATUS_UNDERFLOW;
               end else begin
                  rsp_payload_in.popped_value = back_head;
                  back_cmd.op  = CELL_FROM_HIGH;
                  count_in     = count_ff - 1'b1;
               end
            end
         endcase
      end

      rsp_payload_in.occupancy = OCC_W'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   deq_row #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_front_row (
      .clock     (clock),
      .cmd       (front_cmd),
      .count     (count_ff),
      .head_data (front_head)
   );

   deq_row #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_back_row (
      .clock     (clock),
      .cmd       (back_cmd),
      .count     (count_ff),
      .head_data (back_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### test/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed table, random traffic, back-pressure.
module double_ended_queue_tb;
   import deq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP          = DEFAULT_CAPACITY;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 120;

   typedef struct {
      kind_type               kind;
      logic [DATA_W-1:0]      value;
      int                     reps;
      bit                     typed;
      status_type             status;
      logic [DATA_W-1:0]      popped;
      logic [OCC_W-1:0]       occ;
   } step_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   deq_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   deq_rsp_type rsp_payload;

   // Shadow copy of the queue contents, with its ring front pointer and count.
   logic [DATA_W-1:0] deque_slots [CAP];
   int front_slot = 0;
   int held_count = 0;

   deq_rsp_type expected_rsps [$];

   bit stall_on     = 1'b1;
   bit hold_request = 1'b0;
   int mismatches   = 0;
   int checked_rsps = 0;
   int n_push = 0, n_pop = 0, n_overflow = 0, n_underflow = 0, n_full = 0;
   int quiet_cycles = 0;

   // Rows with typed = 1 carry an expectation that is obvious from the queue's behavior.
   step_row_type directed_steps [20] = '{
      '{KIND_POP_FRONT,  32'h0000_0000,  1, 1'b1, STATUS_UNDERFLOW, 32'h0000_0000, 6'd0},
      '{KIND_POP_BACK,   32'h0000_0000,  1, 1'b1, STATUS_UNDERFLOW, 32'h0000_0000, 6'd0},
      '{KIND_PUSH_BACK,  32'h7fff_ffff,  1, 1'b1, STATUS_OK,        32'h0000_0000, 6'd1},
      '{KIND_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, STATUS_OK,        32'h0000_0000, 6'd2},
      '{KIND_POP_FRONT,  32'h0000_0000,  1, 1'b1, STATUS_OK,        32'h8000_0000, 6'd1},
      '{KIND_POP_BACK,   32'h0000_0000,  1, 1'b1, STATUS_OK,        32'h7fff_ffff, 6'd0},
      '{KIND_PUSH_FRONT, 32'hffff_ffff,  1, 1'b1, STATUS_OK,        32'h0000_0000, 6'd1},
      '{KIND_PUSH_BACK,  32'h0000_0000,  1, 1'b1, STATUS_OK,        32'h0000_0000, 6'd2},
      '{KIND_POP_FRONT,  32'h0000_0000,  1, 1'b1, STATUS_OK,        32'hffff_ffff, 6'd1},
      '{KIND_POP_FRONT,  32'h0000_0000,  1, 1'b1, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_PUSH_BACK,  32'h0000_1000, 16, 1'b0, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_PUSH_FRONT, 32'h5555_0000, 16, 1'b0, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_PUSH_BACK,  32'h1234_5678,  1, 1'b1, STATUS_OVERFLOW,  32'h0000_0000, 6'd32},
      '{KIND_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, STATUS_OVERFLOW,  32'h0000_0000, 6'd32},
      '{KIND_POP_BACK,   32'h0000_0000,  1, 1'b0, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_PUSH_FRONT, 32'h7fff_ffff,  1, 1'b0, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_POP_FRONT,  32'h0000_0000, 17, 1'b0, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_POP_BACK,   32'h0000_0000, 15, 1'b0, STATUS_OK,        32'h0000_0000, 6'd0},
      '{KIND_POP_FRONT,  32'hffff_ffff,  1, 1'b1, STATUS_UNDERFLOW, 32'h0000_0000, 6'd0},
      '{KIND_POP_BACK,   32'haaaa_aaaa,  1, 1'b1, STATUS_UNDERFLOW, 32'h0000_0000, 6'd0}
   };

   double_ended_queue #(.CAPACITY(CAP)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the shadow queue and returns the response it should give.
   function automatic deq_rsp_type apply_op(input deq_req_type word);
      deq_rsp_type r;
      r.status       = STATUS_OK;
      r.popped_value = '0;
      case (word.kind) inside
         KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            if (held_count == CAP) begin
               r.status = STATUS_OVERFLOW;
            end else if (word.kind == KIND_PUSH_BACK) begin
               deque_slots[(front_slot + held_count) % CAP] = word.value;
               held_count++;
            end else begin
               front_slot = (front_slot + CAP - 1) % CAP;
               deque_slots[front_slot] = word.value;
               held_count++;
            end
         end
         default: begin
            if (held_count == 0) begin
               r.status = STATUS_UNDERFLOW;
            end else if (word.kind == KIND_POP_FRONT) begin
               r.popped_value = deque_slots[front_slot];
               front_slot = (front_slot + 1) % CAP;
               held_count--;
            end else begin
               r.popped_value = deque_slots[(front_slot + held_count - 1) % CAP];
               held_count--;
            end
         end
      endcase
      r.occupancy = OCC_W'(held_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("MISMATCH rsp %0d %s: got %h, expected %h", checked_rsps, what, got, want);
      mismatches++;
   endtask

   // Offers one word, idling first at random while stalls are on; valid stays high afterward for the next word.
   task automatic send_word(input deq_req_type word, input bit typed, input deq_rsp_type fixed);
      deq_rsp_type predicted;
      while (stall_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= word;
      do @(posedge clock); while (!req_ready);
      predicted = apply_op(word);
      expected_rsps.push_back(typed ? fixed : predicted);
      if (word.kind == KIND_PUSH_BACK || word.kind == KIND_PUSH_FRONT) n_push++;
      else n_pop++;
      if (predicted.status == STATUS_OVERFLOW) n_overflow++;
      if (predicted.status == STATUS_UNDERFLOW) n_underflow++;
      if (predicted.status == STATUS_OK && predicted.occupancy == OCC_W'(CAP)
          && predicted.popped_value == '0 && word.kind inside {KIND_PUSH_BACK, KIND_PUSH_FRONT})
         n_full++;
   endtask

   // Random operations in segments; with a negative push_pct each segment picks its own
   // push bias so the queue swings between empty and full, else every segment uses push_pct.
   task automatic send_random_ops(input int count, input int push_pct);
      deq_req_type word;
      int          pct;
      int          seg_left;
      int          sent;
      int          biases [5];
      biases   = '{5, 25, 50, 75, 95};
      sent     = 0;
      seg_left = 0;
      pct      = 50;
      while (sent < count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(80, 20);
            pct      = (push_pct < 0) ? biases[$urandom_range(4)] : push_pct;
         end
         if ($urandom_range(99) < pct)
            word.kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
         else
            word.kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
         case ($urandom_range(15))
            0:       word.value = 32'sh7fff_ffff;
            1:       word.value = 32'sh8000_0000;
            2:       word.value = '1;
            3:       word.value = '0;
            default: word.value = $urandom;
         endcase
         send_word(word, 1'b0, '0);
         seg_left--;
         sent++;
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   // Receiver: random back-pressure while stalls are on, plus one long hold-off when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= !(stall_on && $urandom_range(99) < 28);
         end
      end
   end

   always @(posedge clock) begin
      deq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected word", rsp_payload.popped_value, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", DATA_W'(rsp_payload.status), DATA_W'(want.status));
            if (rsp_payload.popped_value !== want.popped_value)
               report_mismatch("popped_value", rsp_payload.popped_value, want.popped_value);
            if (rsp_payload.occupancy !== want.occupancy)
               report_mismatch("occupancy", DATA_W'(rsp_payload.occupancy),
                               DATA_W'(want.occupancy));
         end
         checked_rsps++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      deq_req_type word;
      deq_rsp_type fixed;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[r]) begin
         for (int i = 0; i < directed_steps[r].reps; i++) begin
            word.kind          = directed_steps[r].kind;
            word.value         = directed_steps[r].value + i;
            fixed.status       = directed_steps[r].status;
            fixed.popped_value = directed_steps[r].popped;
            fixed.occupancy    = directed_steps[r].occ;
            send_word(word, directed_steps[r].typed, fixed);
         end
      end

      send_random_ops(500, -1);

      // A long stretch with both sides running flat out.
      stall_on = 1'b0;
      send_random_ops(300, -1);

      // Receiver holds off while the sender keeps pushing, stalling the input.
      stall_on     = 1'b1;
      hold_request = 1'b1;
      send_random_ops(60, 90);
      drain_all();

      send_random_ops(400, -1);
      drain_all();
      send_random_ops(400, -1);

      drain_all();
      repeat (4) @(posedge clock);
      $display("Ran %0d operations: %0d pushes, %0d pops, %0d responses checked.",
               n_push + n_pop, n_push, n_pop, checked_rsps);
      $display("Saw %0d overflows, %0d underflows, queue filled to capacity %0d times.",
               n_overflow, n_underflow, n_full);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
src/deq_pkg.sv
src/deq_cell.sv
src/deq_row.sv
src/double_ended_queue.sv
test/double_ended_queue_tb.sv
